/* sv/double_ended_stack_allocator_unit_macros.svh */
// assertion macros for the double-ended stack allocator
// used by the top level only, no other dependencies
`ifndef DOUBLE_ENDED_STACK_ALLOCATOR_UNIT_MACROS_SVH
`define DOUBLE_ENDED_STACK_ALLOCATOR_UNIT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define DESA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define DESA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/desa_pkg.sv */
// shared types and constants for the double-ended stack allocator
// no dependencies
package desa_pkg;

    localparam int ADDR_BITS_DEF   = 16;
    localparam int STACK_DEPTH_DEF = 16;

    localparam int CMD_W    = 3;
    localparam int SIZE_W   = 17;
    localparam int ALIGN_W  = 4;
    localparam int FADDR_W  = 16;
    localparam int ADDR_W   = 16;
    localparam int STATUS_W = 3;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 16;

    localparam logic [SIZE_W-1:0] POOL_RESET = 17'h10000;

    // commands
    localparam logic [CMD_W-1:0] CMD_ALLOC_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ALLOC_BACK  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_FREE_FRONT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_FREE_BACK   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_RESET       = 3'd4;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_OOM     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BADADDR = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd4;

    // operation on one size stack
    typedef struct packed {
        logic push;
        logic pop;
        logic clear;
    } t_stack_op;

endpackage

/* sv/desa_size_stack.sv */
// chunk size stack for one end of the pool: fill count plus memory
// depends on desa_pkg
module desa_size_stack #(
    parameter int STACK_DEPTH = desa_pkg::STACK_DEPTH_DEF,
    parameter int CNT_W       = $clog2(STACK_DEPTH + 1)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  desa_pkg::t_stack_op         i_op,
    input  logic [desa_pkg::SIZE_W-1:0] i_push_size,
    output logic [CNT_W-1:0]            o_count,
    output logic [desa_pkg::SIZE_W-1:0] o_top
);

    localparam int IDX_W = $clog2(STACK_DEPTH);

    logic [desa_pkg::SIZE_W-1:0] r_mem [STACK_DEPTH];
    logic [desa_pkg::SIZE_W-1:0] r_top;
    logic [CNT_W-1:0]            r_count;
    logic [CNT_W-1:0]            n_count;
    logic [CNT_W-1:0]            rd_cnt;
    logic [IDX_W-1:0]            rd_idx;
    logic [IDX_W-1:0]            wr_idx;

    always_comb begin
        priority if (i_op.clear) begin
            n_count = '0;
        end else if (i_op.push) begin
            n_count = r_count + CNT_W'(1);
        end else if (i_op.pop) begin
            n_count = r_count - CNT_W'(1);
        end else begin
            n_count = r_count;
        end
    end

    // read the entry that will be on top next cycle
    assign rd_cnt = n_count - CNT_W'(1);
    assign rd_idx = rd_cnt[IDX_W-1:0];
    assign wr_idx = r_count[IDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_op.push) begin
            r_mem[wr_idx] <= i_push_size;
        end
        // forward a push to the same entry
        if (i_op.push && (wr_idx == rd_idx)) begin
            r_top <= i_push_size;
        end else begin
            r_top <= r_mem[rd_idx];
        end
    end

    assign o_count = r_count;
    assign o_top   = r_top;

endmodule

/* sv/double_ended_stack_allocator_unit.sv */
// double-ended stack allocator: a command passes the input register and then the result
// register, whose valid flag drives tvalid; throughput one command per cycle while the
// output is not stalled; each command runs in an execute stage that reads and updates the
// markers and the registered top-of-stack entries of both size stacks; a stalled output
// holds the execute stage and then the input register; pool size writes take effect at the
// next reset command; synchronous active-low reset clears the back marker, counts and valid
// flags, sets the front marker to the pool top and restores pool size 65536
`include "double_ended_stack_allocator_unit_macros.svh"

module double_ended_stack_allocator_unit #(
    parameter int ADDR_BITS   = desa_pkg::ADDR_BITS_DEF,
    parameter int STACK_DEPTH = desa_pkg::STACK_DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration write channel: pool size in bytes
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [desa_pkg::SIZE_W-1:0]      i_cfg_data,
    // command stream
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // chunk_size[16:0], align_log2[20:17], free_address[36:21], zero pad
    input  logic [desa_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // command[2:0]
    input  logic [desa_pkg::CMD_W-1:0]       s_axis_tuser,
    // result stream
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // address[15:0]
    output logic [desa_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // status[2:0]
    output logic [desa_pkg::STATUS_W-1:0]    m_axis_tuser
);

    localparam int MW    = ADDR_BITS + 1;                  // marker width
    localparam int WW    = ((MW > desa_pkg::SIZE_W) ? MW : desa_pkg::SIZE_W) + 2;
    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int AM_W  = (1 << desa_pkg::ALIGN_W) - 1;   // alignment mask width

    localparam logic [WW-1:0] CAP       = WW'(1) << ADDR_BITS;
    localparam logic [WW-1:0] RST_POOL  = WW'(desa_pkg::POOL_RESET);
    localparam logic [WW-1:0] RST_FRONT = (RST_POOL > CAP) ? CAP : RST_POOL;
    localparam logic [CNT_W-1:0] DEPTH  = CNT_W'(STACK_DEPTH);

    // configuration
    logic [desa_pkg::SIZE_W-1:0] r_pool_bytes;

    // input register
    logic                         r_in_valid;
    logic [desa_pkg::CMD_W-1:0]   r_cmd;
    logic [desa_pkg::SIZE_W-1:0]  r_size;
    logic [desa_pkg::ALIGN_W-1:0] r_align;
    logic [desa_pkg::FADDR_W-1:0] r_faddr;

    // allocator state
    logic [MW-1:0] r_back_marker;
    logic [MW-1:0] r_front_marker;
    logic [MW-1:0] n_back_marker;
    logic [MW-1:0] n_front_marker;

    // result register
    logic                          r_out_valid;
    logic [desa_pkg::ADDR_W-1:0]   r_out_addr;
    logic [desa_pkg::STATUS_W-1:0] r_out_status;
    logic [desa_pkg::ADDR_W-1:0]   n_out_addr;
    logic [desa_pkg::STATUS_W-1:0] n_out_status;

    // size stacks
    desa_pkg::t_stack_op         front_op;
    desa_pkg::t_stack_op         back_op;
    logic [CNT_W-1:0]            front_count;
    logic [CNT_W-1:0]            back_count;
    logic [desa_pkg::SIZE_W-1:0] front_top;
    logic [desa_pkg::SIZE_W-1:0] back_top;

    // handshake
    logic advance;   // execute stage may move on
    logic exec;      // a command executes this cycle
    logic in_hs;

    // execute datapath
    logic [AM_W-1:0] amask_n;
    logic [WW-1:0]   amask;
    logic [WW-1:0]   size_w;
    logic [WW-1:0]   front_w;
    logic [WW-1:0]   back_w;
    logic [WW-1:0]   front_top_w;
    logic [WW-1:0]   back_top_w;
    logic [WW-1:0]   faddr_w;
    logic [WW-1:0]   pool_w;
    logic [WW-1:0]   pool_size;
    logic [WW-1:0]   front_pos;
    logic [WW-1:0]   back_pos;
    logic [WW-1:0]   back_end;
    logic [WW-1:0]   back_base;

    assign o_cfg_ready   = 1'b1;
    assign advance       = !r_out_valid || m_axis_tready;
    assign exec          = r_in_valid && advance;
    assign s_axis_tready = !r_in_valid || advance;
    assign in_hs         = s_axis_tvalid && s_axis_tready;

    // widen everything to one working width so that compares and sums cannot wrap
    assign amask_n     = AM_W'((AM_W + 1)'(1) << r_align) - AM_W'(1);
    assign amask       = WW'(amask_n);
    assign size_w      = WW'(r_size);
    assign front_w     = WW'(r_front_marker);
    assign back_w      = WW'(r_back_marker);
    assign front_top_w = WW'(front_top);
    assign back_top_w  = WW'(back_top);
    assign faddr_w     = WW'(r_faddr);
    assign pool_w      = WW'(r_pool_bytes);
    assign pool_size   = (pool_w > CAP) ? CAP : pool_w;

    // front chunk sits at the aligned-down position below the front marker
    assign front_pos = (front_w - size_w) & ~amask;
    // back chunk sits at the aligned-up back marker
    assign back_pos  = (back_w + amask) & ~amask;
    assign back_end  = back_pos + size_w;
    // start of the top back chunk
    assign back_base = back_w - back_top_w;

    always_comb begin
        n_back_marker  = r_back_marker;
        n_front_marker = r_front_marker;
        n_out_addr     = '0;
        n_out_status   = desa_pkg::ST_OK;
        front_op       = '0;
        back_op        = '0;
        unique case (r_cmd)
            desa_pkg::CMD_ALLOC_FRONT: begin
                priority if (front_count >= DEPTH) begin
                    n_out_status = desa_pkg::ST_FULL;
                end else if (size_w > front_w) begin
                    n_out_status = desa_pkg::ST_OOM;
                end else if (front_pos < back_w) begin
                    n_out_status = desa_pkg::ST_OOM;
                end else begin
                    n_front_marker = front_pos[MW-1:0];
                    n_out_addr     = front_pos[desa_pkg::ADDR_W-1:0];
                    front_op.push  = exec;
                end
            end
            desa_pkg::CMD_ALLOC_BACK: begin
                priority if (back_count >= DEPTH) begin
                    n_out_status = desa_pkg::ST_FULL;
                end else if (back_end > front_w) begin
                    n_out_status = desa_pkg::ST_OOM;
                end else begin
                    n_back_marker = back_end[MW-1:0];
                    n_out_addr    = back_pos[desa_pkg::ADDR_W-1:0];
                    back_op.push  = exec;
                end
            end
            desa_pkg::CMD_FREE_FRONT: begin
                priority if (front_count == '0) begin
                    n_out_status = desa_pkg::ST_EMPTY;
                end else if (faddr_w != front_w) begin
                    n_out_status = desa_pkg::ST_BADADDR;
                end else begin
                    n_front_marker = MW'(front_w + front_top_w);
                    front_op.pop   = exec;
                end
            end
            desa_pkg::CMD_FREE_BACK: begin
                priority if (back_count == '0) begin
                    n_out_status = desa_pkg::ST_EMPTY;
                end else if ((back_top_w > back_w) || (faddr_w != back_base)) begin
                    n_out_status = desa_pkg::ST_BADADDR;
                end else begin
                    n_back_marker = back_base[MW-1:0];
                    back_op.pop   = exec;
                end
            end
            desa_pkg::CMD_RESET: begin
                n_back_marker  = '0;
                n_front_marker = pool_size[MW-1:0];
                front_op.clear = exec;
                back_op.clear  = exec;
            end
            default: begin
                // unused command codes: no state change, status ok
            end
        endcase
    end

    desa_size_stack #(
        .STACK_DEPTH (STACK_DEPTH),
        .CNT_W       (CNT_W)
    ) u_front_stack (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (front_op),
        .i_push_size (r_size),
        .o_count     (front_count),
        .o_top       (front_top)
    );

    desa_size_stack #(
        .STACK_DEPTH (STACK_DEPTH),
        .CNT_W       (CNT_W)
    ) u_back_stack (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (back_op),
        .i_push_size (r_size),
        .o_count     (back_count),
        .o_top       (back_top)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_bytes   <= desa_pkg::POOL_RESET;
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_back_marker  <= '0;
            r_front_marker <= RST_FRONT[MW-1:0];
        end else begin
            if (i_cfg_valid) begin
                r_pool_bytes <= i_cfg_data;
            end
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
            if (exec) begin
                r_back_marker  <= n_back_marker;
                r_front_marker <= n_front_marker;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_hs) begin
            r_size  <= s_axis_tdata[16:0];
            r_align <= s_axis_tdata[20:17];
            r_faddr <= s_axis_tdata[36:21];
            r_cmd   <= s_axis_tuser;
        end
        if (exec) begin
            r_out_addr   <= n_out_addr;
            r_out_status <= n_out_status;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_addr;
    assign m_axis_tuser  = r_out_status;

    // the two stacks never overlap
    `DESA_ASSERT_IMPL(a_markers_ordered, i_clk, i_rst_n, 1'b1, r_back_marker <= r_front_marker, "back marker passed front marker")

    // fill counts stay within the stack depth
    `DESA_ASSERT_IMPL(a_counts_bounded, i_clk, i_rst_n, 1'b1, (front_count <= DEPTH) && (back_count <= DEPTH), "size stack count beyond depth")

    // a failed transaction carries address zero
    `DESA_ASSERT_IMPL(a_fail_addr_zero, i_clk, i_rst_n, r_out_valid && (r_out_status != desa_pkg::ST_OK), r_out_addr == '0, "failed transaction with nonzero address")

    // a reset command empties both stacks
    `DESA_ASSERT_NEXT(a_reset_cmd_clears, i_clk, i_rst_n, exec && (r_cmd == desa_pkg::CMD_RESET), (front_count == '0) && (back_count == '0) && (r_back_marker == '0), "reset command left state behind")

endmodule
